// File: src/ins_pkg.sv
// Shared constants and types for the insertion sorter.
package ins_pkg;

    // Number of cells in the sorting chain
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned DATA_W   = 32;

    // Control state of the sorter
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                     insert;
        logic                     shift_out;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    // What a cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic signed [DATA_W-1:0] value;
    } t_cell_link;

endpackage

// File: src/ins_in_if.sv
// Input word channel: value to insert and end-of-set mark.
interface ins_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               end_of_set;

    modport source (output valid, output value, output end_of_set, input ready);
    modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

// File: src/ins_out_if.sv
// Output word channel: sorted value with final and dropped flags.
interface ins_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sorted_value;
    logic               final_item;
    logic               dropped;

    modport source (output valid, output sorted_value, output final_item,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input final_item,
                    input dropped, output ready);
endinterface

// File: src/ins_cell.sv
// One cell of the insertion chain: holds one stored value and its valid bit.
module ins_cell
    import ins_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_link i_left,
    input  t_cell_link i_right,
    output t_cell_link o_link
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_value;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_value;
    logic                     w_gt;

    // Stored value strictly above the incoming word: this cell must move up
    assign w_gt = r_valid && (r_value > i_ctl.value);

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

    // Insert: take the left value if it moves up, else take the new word if
    // this is its slot. Drain: pull from the right neighbor toward the head.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.shift_out) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ctl.insert) begin
            if (i_left.gt) begin
                n_valid = 1'b1;
                n_value = i_left.value;
            end else if (w_gt || (!r_valid && i_left.valid)) begin
                n_valid = 1'b1;
                n_value = i_ctl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload holds no reset
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// File: src/insertion_sorter.sv
// Insertion sorter top level: controller and chain of sorting cells.
//
// Usage: signed 32-bit words arrive on i_in (valid/ready). Each accepted word
// is inserted into a chain of CAPACITY cells; every cell compares
// against the broadcast word and larger entries move up one place, so equal
// values keep their arrival order. A full chain discards the word and sets
// the dropped flag for the current set.
// A word with end_of_set high is inserted like the others; from the next cycle
// the chain drains through o_out, smallest first, one word per cycle while
// o_out.ready is high. final_item marks the largest word, dropped is high on
// every word of a set that lost elements.
// Throughput: one input word per cycle while filling; input ready is low
// during the drain, in which the stored words leave one by one through the
// single shift path from the chain head to o_out.
// The first sorted word appears on o_out in the cycle after the end-of-set word.
// A receiver stall freezes the chain; nothing is lost or repeated.
// Reset (synchronous, active low) empties the chain and clears the flag;
// the stored values themselves are not cleared.
module insertion_sorter
    import ins_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ins_in_if.sink    i_in,
    ins_out_if.source o_out
);

    t_state     r_state;
    t_state     n_state;
    logic       r_overflow;
    logic       n_overflow;
    t_cell_ctl  w_ctl;
    t_cell_link w_link  [CAPACITY];
    t_cell_link w_left  [CAPACITY];
    t_cell_link w_right [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic       w_full;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_last_out;

    // Handshakes
    assign i_in.ready = (r_state == ST_FILL);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_full     = w_link[CAPACITY-1].valid;
    assign w_last_out = w_out_acc && !w_link[1].valid;

    // Broadcast to the cells
    assign w_ctl.insert    = w_in_acc && !w_full;
    assign w_ctl.shift_out = w_out_acc;
    assign w_ctl.value     = i_in.value;

    // Chain of cells; the head sees an occupied, never-larger left neighbor
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_left[g] = '{valid: 1'b1, gt: 1'b0, value: '0};
            end else begin : g_body
                assign w_left[g] = w_link[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_right[g] = '{valid: 1'b0, gt: 1'b0, value: '0};
            end else begin : g_mid
                assign w_right[g] = w_link[g+1];
            end
            assign w_valid[g] = w_link[g].valid;

            ins_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_link  (w_link[g])
            );
        end
    endgenerate

    // Output word comes straight from the chain head
    assign o_out.valid        = (r_state == ST_DRAIN) && w_link[0].valid;
    assign o_out.sorted_value = w_link[0].value;
    assign o_out.final_item   = !w_link[1].valid;
    assign o_out.dropped      = r_overflow;

    // Next state and overflow flag
    always_comb begin
        n_state    = r_state;
        n_overflow = r_overflow;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc && w_full) begin
                    n_overflow = 1'b1;
                end
                if (w_in_acc && i_in.end_of_set) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_last_out) begin
                    n_state    = ST_FILL;
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    // Occupied cells always form an unbroken run from the head
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("chain has a hole");

    // A word inserted into a chain with room adds exactly one entry
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |=> $countones(w_valid) == $past($countones(w_valid)) + 1)
        else $error("insert did not add one entry");

    // A word arriving at a full chain marks the set as dropped
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_full) |=> r_overflow)
        else $error("overflow not recorded");

    // Taking the final word empties the chain and reopens the input
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.final_item) |=> (r_state == ST_FILL) && !w_valid[0]
            && !r_overflow)
        else $error("drain did not finish cleanly");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the insertion sorter: directed table, then random sets.
module tb_top;
    import ins_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_GOAL  = 470;
    localparam int unsigned DRAIN_WAIT = 20000;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

    // One sorted word as it leaves the block
    typedef struct packed {
        logic signed [31:0] value;
        logic               final_item;
        logic               dropped;
    } t_sorted_word;

    // One row of the directed table; known marks a single-item set whose
    // only result is typed in here
    typedef struct packed {
        logic signed [31:0] value;
        logic               end_of_set;
        logic               known;
        logic signed [31:0] known_value;
    } t_stim_row;

    localparam int unsigned N_ROWS = 24;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet = 1'b0;
    int   errors = 0;

    // Predictor state: current set in ascending order, and the overflow flag
    logic signed [31:0] held_vals[$];
    logic               spill_seen = 1'b0;
    t_sorted_word       sorted_q[$];

    // Extremes as single sets, a small set with duplicates, then an overflowing
    // set whose end-of-set word itself is dropped
    t_stim_row stim_tab [N_ROWS] = '{
        '{S32_MIN,      1'b1, 1'b1, S32_MIN},
        '{S32_MAX,      1'b1, 1'b1, S32_MAX},
        '{32'sd0,       1'b1, 1'b1, 32'sd0},
        '{-32'sd1,      1'b0, 1'b0, 32'sd0},
        '{32'sd5,       1'b0, 1'b0, 32'sd0},
        '{32'sd5,       1'b0, 1'b0, 32'sd0},
        '{S32_MIN,      1'b1, 1'b0, 32'sd0},
        '{32'sd100,     1'b0, 1'b0, 32'sd0},
        '{-32'sd100,    1'b0, 1'b0, 32'sd0},
        '{32'sd7,       1'b0, 1'b0, 32'sd0},
        '{32'sd7,       1'b0, 1'b0, 32'sd0},
        '{32'sd0,       1'b0, 1'b0, 32'sd0},
        '{S32_MAX,      1'b0, 1'b0, 32'sd0},
        '{S32_MIN,      1'b0, 1'b0, 32'sd0},
        '{-32'sd1,      1'b0, 1'b0, 32'sd0},
        '{32'sd1,       1'b0, 1'b0, 32'sd0},
        '{32'sd42,      1'b0, 1'b0, 32'sd0},
        '{32'sd42,      1'b0, 1'b0, 32'sd0},
        '{-32'sd42,     1'b0, 1'b0, 32'sd0},
        '{32'sd3,       1'b0, 1'b0, 32'sd0},
        '{32'sd2,       1'b0, 1'b0, 32'sd0},
        '{32'sh5555_AAAA, 1'b0, 1'b0, 32'sd0},
        '{32'shAAAA_5555, 1'b0, 1'b0, 32'sd0},
        '{32'sd9,       1'b1, 1'b0, 32'sd0}
    };

    ins_in_if  in_if ();
    ins_out_if out_if ();

    insertion_sorter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Insert one accepted word into the predicted set; end of set releases it
    function automatic void insert_and_release(input logic signed [31:0] v,
                                               input logic eos);
        int unsigned slot;
        int unsigned n;
        t_sorted_word next_word;
        if (held_vals.size() >= CAPACITY) begin
            spill_seen = 1'b1;
        end else begin
            slot = held_vals.size();
            // strictly greater entries move up, equal ones stay below
            while (slot > 0 && v < held_vals[slot-1])
                slot--;
            held_vals.insert(slot, v);
        end
        if (eos) begin
            n = held_vals.size();
            for (int unsigned k = 0; k < n; k++) begin
                next_word.value      = held_vals[k];
                next_word.final_item = (k + 1 == n);
                next_word.dropped    = spill_seen;
                sorted_q = {sorted_q, next_word};
            end
            held_vals.delete();
            spill_seen = 1'b0;
        end
    endfunction

    // Values: duplicates from a narrow range, full range, or extremes
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(2))
            0: v = $signed($urandom_range(8)) - 32'sd4;
            1: v = $urandom;
            default: begin
                case ($urandom_range(5))
                    0: v = S32_MIN;
                    1: v = S32_MAX;
                    2: v = S32_MIN + 32'sd1;
                    3: v = S32_MAX - 32'sd1;
                    4: v = -32'sd1;
                    default: v = 32'sd0;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offer one word, with random idle cycles ahead of it; returns at acceptance
    task automatic send_word(input logic signed [31:0] v, input logic eos);
        while (!quiet && $urandom_range(99) < 12) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.value      <= v;
        in_if.end_of_set <= eos;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
    endtask

    // Output side: random stalls, none during the quiet stretch
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= quiet || ($urandom_range(99) >= 12);
        end
    end

    // Compare every accepted sorted word with the oldest prediction
    always @(posedge clk) begin
        t_sorted_word got;
        t_sorted_word want;
        if (rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.sorted_value, out_if.final_item, out_if.dropped};
            if (sorted_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected sorted word value=%0d final=%0b dropped=%0b",
                         $realtime, got.value, got.final_item, got.dropped);
            end else begin
                want = sorted_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected value=%0d final=%0b dropped=%0b",
                             $realtime, want.value, want.final_item, want.dropped,
                             ", got value=%0d final=%0b dropped=%0b",
                             got.value, got.final_item, got.dropped);
                end
            end
        end
    end

    // Main sequence
    initial begin
        int unsigned sent;
        int unsigned set_len;
        int unsigned waited;
        int unsigned pick;

        sent = 0;
        rst_n            <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.value      <= '0;
        in_if.end_of_set <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (stim_tab[r]) begin
            send_word(stim_tab[r].value, stim_tab[r].end_of_set);
            insert_and_release(stim_tab[r].value, stim_tab[r].end_of_set);
            if (stim_tab[r].known)
                sorted_q[sorted_q.size()-1] = '{stim_tab[r].known_value, 1'b1, 1'b0};
            sent++;
        end

        // random sets: mostly within capacity, some exactly full, some overflowing
        while (sent < ITEM_GOAL) begin
            pick = $urandom_range(99);
            if (pick < 70)
                set_len = $urandom_range(CAPACITY, 1);
            else if (pick < 85)
                set_len = CAPACITY;
            else
                set_len = $urandom_range(CAPACITY + 4, CAPACITY + 1);
            for (int unsigned i = 0; i < set_len; i++) begin
                logic signed [31:0] v;
                v = pick_value();
                quiet = (sent >= 150 && sent < 260);
                send_word(v, i + 1 == set_len);
                insert_and_release(v, i + 1 == set_len);
                sent++;
            end
        end
        quiet = 1'b0;
        in_if.valid <= 1'b0;

        waited = 0;
        while (sorted_q.size() != 0 && waited < DRAIN_WAIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (CAPACITY + 4) @(posedge clk);

        if (sorted_q.size() != 0) begin
            errors++;
            $display("%0t: %0d sorted words never arrived, next expected value=%0d",
                     $realtime, sorted_q.size(), sorted_q[0].value);
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
src/ins_pkg.sv
src/ins_in_if.sv
src/ins_out_if.sv
src/ins_cell.sv
src/insertion_sorter.sv
tb/sv/tb_top.sv
